// File: rtl/sfe_pkg.sv
// Shared types and constants of the SBUS frame encoder.
// Used by the interfaces and by every module of the block; depends on nothing.
package sfe_pkg;

  localparam int PULSE_W        = 12;
  localparam int CODE_W         = 11;
  localparam int BYTE_W         = 8;
  localparam int COUNT_W        = 5;
  localparam int ANALOG_IDX_W   = 4;
  localparam int NUM_W          = 23;
  localparam int ACC_W          = CODE_W + BYTE_W - 1;
  localparam int ANALOG_CHANNELS = 16;
  localparam int TOTAL_CHANNELS  = 18;
  localparam int QUEUE_DEPTH    = 2;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [BYTE_W-1:0]  SYNC_BYTE         = 8'h0F;
  localparam logic [BYTE_W-1:0]  END_BYTE          = 8'h00;
  localparam logic [PULSE_W-1:0] DIGITAL_THRESHOLD = 12'd1500;
  localparam logic [CODE_W-1:0]  CODE_MIN          = 11'd192;
  localparam logic [CODE_W-1:0]  CODE_MAX          = 11'd1792;
  localparam logic [CODE_W-1:0]  CODE_SPAN         = 11'd1600;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RESET   = 12'd1000;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RESET   = 12'd2000;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_PULSE = 1'b0;
  localparam logic REG_MAX_PULSE = 1'b1;

  typedef enum logic {
    CMD_ANALOG,
    CMD_FLAG
  } cmd_kind_t;

  // One classified channel, handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t                kind;
    logic [ANALOG_IDX_W-1:0]  index;
    logic                     empty_range;
    logic [PULSE_W-1:0]       offset;
    logic [PULSE_W-1:0]       span;
    logic                     level;
    logic                     frame_end;
  } cmd_t;

  typedef struct packed {
    logic [PULSE_W-1:0] offset;
    logic [PULSE_W-1:0] span;
  } scale_req_t;

endpackage

// File: rtl/sfe_if.sv
// Valid/ready stream interfaces for the pulse input and the frame byte output.
// Depends on sfe_pkg for the field widths.
interface sfe_in_if;
  logic                         valid;
  logic                         ready;
  logic [sfe_pkg::PULSE_W-1:0]  pulse_us;

  modport source (output valid, output pulse_us, input ready);
  modport sink   (input valid, input pulse_us, output ready);
endinterface

interface sfe_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfe_pkg::BYTE_W-1:0]  frame_byte;
  logic                        last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// File: rtl/sfe_front.sv
// Front end: accepts channel pulse widths, counts channels and classifies each one.
// Depends on sfe_pkg and sfe_in_if.
module sfe_front (
  input  logic                        clk,
  input  logic                        rst,
  sfe_in_if.sink                      pulse_in,
  input  logic [sfe_pkg::PULSE_W-1:0] min_pulse,
  input  logic [sfe_pkg::PULSE_W-1:0] max_pulse,
  input  logic                        full,
  output logic                        push,
  output sfe_pkg::cmd_t               push_cmd
);

  logic [sfe_pkg::COUNT_W-1:0] channel_count;
  logic [sfe_pkg::PULSE_W-1:0] clamped;
  logic                        is_analog;
  logic                        is_last;

  assign pulse_in.ready = !full;
  assign push           = pulse_in.valid && !full;

  assign is_analog = channel_count < sfe_pkg::COUNT_W'(sfe_pkg::ANALOG_CHANNELS);
  assign is_last   = channel_count == sfe_pkg::COUNT_W'(sfe_pkg::TOTAL_CHANNELS - 1);

  always_comb begin
    if (pulse_in.pulse_us < min_pulse) begin
      clamped = min_pulse;
    end else if (pulse_in.pulse_us > max_pulse) begin
      clamped = max_pulse;
    end else begin
      clamped = pulse_in.pulse_us;
    end
  end

  always_comb begin
    push_cmd.kind        = is_analog ? sfe_pkg::CMD_ANALOG : sfe_pkg::CMD_FLAG;
    // Digital channels use the low index bit to pick their flag.
    push_cmd.index       = channel_count[sfe_pkg::ANALOG_IDX_W-1:0];
    push_cmd.empty_range = max_pulse <= min_pulse;
    push_cmd.offset      = clamped - min_pulse;
    push_cmd.span        = max_pulse - min_pulse;
    push_cmd.level       = pulse_in.pulse_us >= sfe_pkg::DIGITAL_THRESHOLD;
    push_cmd.frame_end   = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= '0;
    end else if (push) begin
      if (is_last) begin
        channel_count <= '0;
      end else begin
        channel_count <= channel_count + sfe_pkg::COUNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/sfe_queue.sv
// Short command queue between the front end and the back end.
// Depends on sfe_pkg for the command type.
module sfe_queue #(
  parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sfe_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfe_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/sfe_scaler.sv
// Scaling unit: multiplies the pulse offset by the code span, divides by the
// pulse span one quotient bit per cycle, rounds to nearest, ties to even, and
// adds the lowest code, clamped to the highest code. Depends on sfe_pkg.
module sfe_scaler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  sfe_pkg::scale_req_t        req,
  output logic                       done,
  output logic [sfe_pkg::CODE_W-1:0] code
);

  localparam int STEP_W = $clog2(sfe_pkg::NUM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_ROUND
  } state_t;

  state_t                      state;
  logic [sfe_pkg::PULSE_W-1:0] offset;
  logic [sfe_pkg::PULSE_W-1:0] span;
  logic [sfe_pkg::NUM_W-1:0]   quot;
  logic [sfe_pkg::PULSE_W-1:0] rem;
  logic [STEP_W-1:0]           step;

  logic [sfe_pkg::PULSE_W:0]   rem_sh;
  logic                        ge;
  logic [sfe_pkg::PULSE_W-1:0] rem_next;
  logic [sfe_pkg::CODE_W-1:0]  q;
  logic [sfe_pkg::PULSE_W:0]   twice_rem;
  logic                        round_up;
  logic [sfe_pkg::CODE_W:0]    rounded;

  // Restoring division step: the remainder always stays below the divisor.
  assign rem_sh   = {rem, quot[sfe_pkg::NUM_W-1]};
  assign ge       = rem_sh >= {1'b0, span};
  assign rem_next = ge ? sfe_pkg::PULSE_W'(rem_sh - {1'b0, span})
                       : rem_sh[sfe_pkg::PULSE_W-1:0];

  assign q         = quot[sfe_pkg::CODE_W-1:0];
  assign twice_rem = {rem, 1'b0};
  assign round_up  = (twice_rem > {1'b0, span}) || ((twice_rem == {1'b0, span}) && q[0]);
  assign rounded   = {1'b0, q} + (sfe_pkg::CODE_W + 1)'(round_up)
                   + {1'b0, sfe_pkg::CODE_MIN};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            offset <= req.offset;
            span   <= req.span;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          quot  <= sfe_pkg::NUM_W'(offset) * sfe_pkg::NUM_W'(sfe_pkg::CODE_SPAN);
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          quot <= {quot[sfe_pkg::NUM_W-2:0], ge};
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(sfe_pkg::NUM_W - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rounded > {1'b0, sfe_pkg::CODE_MAX}) begin
            code <= sfe_pkg::CODE_MAX;
          end else begin
            code <= rounded[sfe_pkg::CODE_W-1:0];
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/sfe_back.sv
// Back end: executes queued channel commands, keeps the channel codes and flags,
// and sends the 25-byte frame through a registered output.
// Depends on sfe_pkg, sfe_out_if and sfe_scaler.
module sfe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  sfe_pkg::cmd_t pop_cmd,
  output logic          pop,
  sfe_out_if.source     frame_out
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SYNC,
    ST_FETCH,
    ST_LOAD,
    ST_PACK,
    ST_FLAGS,
    ST_END
  } state_t;

  localparam int ACC_W  = sfe_pkg::ACC_W;
  localparam int CNT_W  = $clog2(ACC_W + 1);
  localparam int IDX_W  = sfe_pkg::ANALOG_IDX_W + 1;

  state_t                             state;
  logic [sfe_pkg::CODE_W-1:0]         codes [sfe_pkg::ANALOG_CHANNELS];
  logic [sfe_pkg::CODE_W-1:0]         rd_data;
  logic [1:0]                         digital_flags;
  logic [sfe_pkg::ANALOG_IDX_W-1:0]   cur_index;
  logic [IDX_W-1:0]                   code_idx;
  logic [ACC_W-1:0]                   acc;
  logic [CNT_W-1:0]                   cnt;
  logic                               out_valid;
  logic [sfe_pkg::BYTE_W-1:0]         out_byte;
  logic                               out_last;
  logic                               can_send;
  logic                               out_load;

  logic                               scale_start;
  sfe_pkg::scale_req_t                scale_req;
  logic                               scale_done;
  logic [sfe_pkg::CODE_W-1:0]         scale_code;

  logic                               code_we;
  logic [sfe_pkg::ANALOG_IDX_W-1:0]   code_waddr;
  logic [sfe_pkg::CODE_W-1:0]         code_wdata;

  assign can_send = !out_valid || frame_out.ready;
  assign pop      = (state == ST_IDLE) && !empty;

  // A new frame byte enters the output register in this cycle.
  assign out_load = can_send && ((state == ST_SYNC) || (state == ST_FLAGS) ||
                    (state == ST_END) ||
                    ((state == ST_PACK) && (cnt >= CNT_W'(sfe_pkg::BYTE_W))));

  assign scale_start      = pop && (pop_cmd.kind == sfe_pkg::CMD_ANALOG) && !pop_cmd.empty_range;
  assign scale_req.offset = pop_cmd.offset;
  assign scale_req.span   = pop_cmd.span;

  sfe_scaler u_scaler (
    .clk   (clk),
    .rst   (rst),
    .start (scale_start),
    .req   (scale_req),
    .done  (scale_done),
    .code  (scale_code)
  );

  // An empty pulse range writes the lowest code at once; otherwise the code
  // is written when the scaler finishes.
  always_comb begin
    if (scale_done) begin
      code_we    = 1'b1;
      code_waddr = cur_index;
      code_wdata = scale_code;
    end else begin
      code_we    = pop && (pop_cmd.kind == sfe_pkg::CMD_ANALOG) && pop_cmd.empty_range;
      code_waddr = pop_cmd.index;
      code_wdata = sfe_pkg::CODE_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      codes[code_waddr] <= code_wdata;
    end
    rd_data <= codes[code_idx[sfe_pkg::ANALOG_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      digital_flags <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (pop_cmd.kind == sfe_pkg::CMD_ANALOG) begin
              cur_index <= pop_cmd.index;
              if (!pop_cmd.empty_range) begin
                state <= ST_DIV;
              end
            end else begin
              digital_flags[pop_cmd.index[0]] <= pop_cmd.level;
              if (pop_cmd.frame_end) begin
                state <= ST_SYNC;
              end
            end
          end
        end
        ST_DIV: begin
          if (scale_done) begin
            state <= ST_IDLE;
          end
        end
        ST_SYNC: begin
          if (can_send) begin
            out_byte  <= sfe_pkg::SYNC_BYTE;
            out_last  <= 1'b0;
            code_idx  <= '0;
            acc       <= '0;
            cnt       <= '0;
            state     <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          // The code memory read is registered, so wait here for the read data.
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          acc      <= acc | (ACC_W'(rd_data) << cnt);
          cnt      <= cnt + CNT_W'(sfe_pkg::CODE_W);
          code_idx <= code_idx + IDX_W'(1);
          state    <= ST_PACK;
        end
        ST_PACK: begin
          if (cnt >= CNT_W'(sfe_pkg::BYTE_W)) begin
            if (can_send) begin
              out_byte  <= acc[sfe_pkg::BYTE_W-1:0];
              out_last  <= 1'b0;
              acc       <= acc >> sfe_pkg::BYTE_W;
              cnt       <= cnt - CNT_W'(sfe_pkg::BYTE_W);
            end
          end else if (code_idx == IDX_W'(sfe_pkg::ANALOG_CHANNELS)) begin
            state <= ST_FLAGS;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_FLAGS: begin
          if (can_send) begin
            out_byte  <= {{(sfe_pkg::BYTE_W - 2){1'b0}}, digital_flags};
            out_last  <= 1'b0;
            state     <= ST_END;
          end
        end
        ST_END: begin
          if (can_send) begin
            out_byte  <= sfe_pkg::END_BYTE;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign frame_out.valid      = out_valid;
  assign frame_out.frame_byte = out_byte;
  assign frame_out.last_byte  = out_last;

`ifndef NO_ASSERTIONS
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_byte == sfe_pkg::END_BYTE)
    else $error("last byte of frame is not the end byte");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_PACK |-> cnt <= CNT_W'(ACC_W))
    else $error("bit accumulator overflow");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    scale_done |-> scale_code >= sfe_pkg::CODE_MIN && scale_code <= sfe_pkg::CODE_MAX)
    else $error("scaled code out of range");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    scale_done |-> state == ST_DIV)
    else $error("scaler finished while no division was pending");
`endif

endmodule

// File: rtl/sbus_frame_encoder_core.sv
// SBUS frame encoder: top level with the APB configuration registers.
// Depends on sfe_pkg, sfe_if, sfe_front, sfe_queue and sfe_back.
//
// Feed 18 channel pulse widths in microseconds, channel 0 first. Channels 0 to 15
// are clamped to [min_pulse_us, max_pulse_us] and scaled to 192..1792 (round to
// nearest, ties to even); an empty range gives 192. Channels 16 and 17 become
// flags (1 at 1500 us or more). After channel 17 the block sends the 25-byte frame,
// with last_byte set on the closing zero byte. An analog channel waits for the
// shift-subtract divider, which produces one quotient bit per cycle; a digital
// channel needs no division. A two-entry command queue lets the input keep
// accepting while the divider or the frame output is busy. Codes are kept between
// frames but each frame rewrites all of them before they are read; there is no
// clearing pass after reset.
module sbus_frame_encoder_core #(
  parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  sfe_in_if.sink                         pulse_in,
  sfe_out_if.source                      frame_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfe_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sfe_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sfe_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [sfe_pkg::PULSE_W-1:0] min_pulse_us;
  logic [sfe_pkg::PULSE_W-1:0] max_pulse_us;
  logic                        reg_index;

  logic                        push;
  sfe_pkg::cmd_t               push_cmd;
  logic                        full;
  logic                        pop;
  sfe_pkg::cmd_t               pop_cmd;
  logic                        empty;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse_us <= sfe_pkg::MIN_PULSE_RESET;
      max_pulse_us <= sfe_pkg::MAX_PULSE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        sfe_pkg::REG_MIN_PULSE: min_pulse_us <= pwdata[sfe_pkg::PULSE_W-1:0];
        sfe_pkg::REG_MAX_PULSE: max_pulse_us <= pwdata[sfe_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      sfe_pkg::REG_MIN_PULSE: prdata = sfe_pkg::APB_DATA_W'(min_pulse_us);
      sfe_pkg::REG_MAX_PULSE: prdata = sfe_pkg::APB_DATA_W'(max_pulse_us);
      default:                prdata = '0;
    endcase
  end

  sfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pulse_in  (pulse_in),
    .min_pulse (min_pulse_us),
    .max_pulse (max_pulse_us),
    .full      (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  sfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .frame_out (frame_out)
  );

endmodule

// File: tb/tb_sbus_frame_encoder_core.sv
// Self-checking testbench for the SBUS frame encoder core: drives channel pulse widths,
// programmes the pulse range over APB and checks every frame byte against a local predictor.
// Depends on sfe_pkg, sfe_if and the sbus_frame_encoder_core RTL.
module tb_sbus_frame_encoder_core;

  localparam int FRAME_PAYLOAD_BYTES =
    sfe_pkg::ANALOG_CHANNELS * sfe_pkg::CODE_W / sfe_pkg::BYTE_W;
  localparam int SETTLE_CYCLES       = 150;
  localparam int STALL_LIMIT         = 4000;
  localparam int HOLD_OFF_CYCLES     = 1000;

  localparam logic [sfe_pkg::PULSE_W-1:0] DIRECTED_WIDTHS [sfe_pkg::TOTAL_CHANNELS] = '{
    12'd0, 12'd4095, 12'd999, 12'd1000, 12'd2000, 12'd2001, 12'd1500, 12'd1001,
    12'd1999, 12'd1250, 12'd1750, 12'd1, 12'd2048, 12'd1003, 12'd1997, 12'd4094,
    12'd1500, 12'd1499
  };

  typedef struct packed {
    logic [sfe_pkg::BYTE_W-1:0] frame_byte;
    logic                       last_byte;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sfe_pkg::APB_ADDR_W-1:0] paddr;
  logic [sfe_pkg::APB_DATA_W-1:0] pwdata;
  logic [sfe_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  sfe_in_if  pulse_if ();
  sfe_out_if frame_if ();

  sbus_frame_encoder_core DUT (
    .clk       (clk),
    .rst       (rst),
    .pulse_in  (pulse_if),
    .frame_out (frame_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Predictor state, mirroring the block's registers.
  logic [sfe_pkg::PULSE_W-1:0] min_pulse_reg;
  logic [sfe_pkg::PULSE_W-1:0] max_pulse_reg;
  int unsigned                 next_channel;
  logic [sfe_pkg::CODE_W-1:0]  channel_code [sfe_pkg::ANALOG_CHANNELS];
  logic [1:0]                  flag_bits;
  frame_beat_t                 expected_bytes [$];

  int error_count = 0;
  int send_idle_pct;
  int sink_idle_pct;
  int sink_hold_cycles = 0;
  int stall_cycles = 0;

  function automatic logic [sfe_pkg::CODE_W-1:0] scaled_code(
    input logic [sfe_pkg::PULSE_W-1:0] width);
    int unsigned lo, hi, w, den, num, q, r;
    lo = min_pulse_reg;
    hi = max_pulse_reg;
    w  = width;
    if (hi <= lo) return sfe_pkg::CODE_MIN;
    if (w < lo) w = lo;
    if (w > hi) w = hi;
    den = hi - lo;
    num = (w - lo) * sfe_pkg::CODE_SPAN;
    q = num / den;
    r = num % den;
    // Round to nearest; an exact half goes to the even code.
    if (2 * r > den || (2 * r == den && (q % 2) == 1)) q++;
    q += sfe_pkg::CODE_MIN;
    if (q > sfe_pkg::CODE_MAX) q = sfe_pkg::CODE_MAX;
    return sfe_pkg::CODE_W'(q);
  endfunction

  function automatic void push_beat(input logic [sfe_pkg::BYTE_W-1:0] value,
                                    input logic is_last);
    frame_beat_t beat;
    beat.frame_byte = value;
    beat.last_byte  = is_last;
    expected_bytes.push_back(beat);
  endfunction

  function automatic void predict_channel(input logic [sfe_pkg::PULSE_W-1:0] width);
    logic [sfe_pkg::ANALOG_CHANNELS*sfe_pkg::CODE_W-1:0] payload_bits;
    if (next_channel >= sfe_pkg::TOTAL_CHANNELS) next_channel = 0;
    if (next_channel < sfe_pkg::ANALOG_CHANNELS)
      channel_code[next_channel] = scaled_code(width);
    else
      flag_bits[next_channel - sfe_pkg::ANALOG_CHANNELS] =
        (width >= sfe_pkg::DIGITAL_THRESHOLD);
    if (next_channel + 1 < sfe_pkg::TOTAL_CHANNELS) begin
      next_channel++;
      return;
    end
    next_channel = 0;
    for (int k = 0; k < sfe_pkg::ANALOG_CHANNELS; k++)
      payload_bits[k*sfe_pkg::CODE_W +: sfe_pkg::CODE_W] = channel_code[k];
    push_beat(sfe_pkg::SYNC_BYTE, 1'b0);
    for (int b = 0; b < FRAME_PAYLOAD_BYTES; b++)
      push_beat(payload_bits[b*sfe_pkg::BYTE_W +: sfe_pkg::BYTE_W], 1'b0);
    push_beat({6'b0, flag_bits}, 1'b0);
    push_beat(sfe_pkg::END_BYTE, 1'b1);
  endfunction

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (sink_hold_cycles > 0) begin
      frame_if.ready <= 1'b0;
      sink_hold_cycles--;
    end else begin
      frame_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (!rst && frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected frame byte %0h (last_byte %0b)", frame_if.frame_byte,
               frame_if.last_byte);
        error_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (frame_if.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %0h, got %0h", want.frame_byte, frame_if.frame_byte);
          error_count++;
        end
        if (frame_if.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, got %0b", want.last_byte, frame_if.last_byte);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any accepted transaction on either stream restarts the count.
  always @(posedge clk) begin
    if ((pulse_if.valid === 1'b1 && pulse_if.ready === 1'b1) ||
        (frame_if.valid === 1'b1 && frame_if.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_sbus_frame_encoder_core: done, errors");
      $finish;
    end
  end

  task automatic send_pulse(input logic [sfe_pkg::PULSE_W-1:0] width);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pulse_if.valid    <= 1'b0;
      pulse_if.pulse_us <= sfe_pkg::PULSE_W'($urandom());
      @(negedge clk);
    end
    pulse_if.valid    <= 1'b1;
    pulse_if.pulse_us <= width;
    @(posedge clk);
    while (pulse_if.ready !== 1'b1) @(posedge clk);
    predict_channel(width);
  endtask

  // Stop offering, wait for every outstanding byte, then let the datapath go quiet.
  task automatic drain_and_settle();
    @(negedge clk);
    pulse_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one range register, then reads it back over the same port.
  task automatic write_pulse_reg(input logic reg_idx,
                                 input logic [sfe_pkg::PULSE_W-1:0] value);
    logic [sfe_pkg::APB_DATA_W-1:0] wdata;
    wdata = $urandom();
    wdata[sfe_pkg::PULSE_W-1:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (reg_idx == sfe_pkg::REG_MIN_PULSE) min_pulse_reg = value;
    else max_pulse_reg = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== sfe_pkg::APB_DATA_W'(value)) begin
      $error("prdata: expected %0h, got %0h", value, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_pulse_range(input logic [sfe_pkg::PULSE_W-1:0] lo,
                                 input logic [sfe_pkg::PULSE_W-1:0] hi);
    write_pulse_reg(sfe_pkg::REG_MIN_PULSE, lo);
    write_pulse_reg(sfe_pkg::REG_MAX_PULSE, hi);
  endtask

  function automatic logic [sfe_pkg::PULSE_W-1:0] random_width(input int unsigned channel);
    int lo, hi;
    if (channel >= sfe_pkg::ANALOG_CHANNELS) begin
      // Flags: half the time right around the threshold.
      if ($urandom_range(1) == 0) return sfe_pkg::PULSE_W'($urandom_range(1503, 1497));
      return sfe_pkg::PULSE_W'($urandom_range(4095));
    end
    if ($urandom_range(3) == 0) return sfe_pkg::PULSE_W'($urandom_range(4095));
    lo = (min_pulse_reg < max_pulse_reg) ? min_pulse_reg : max_pulse_reg;
    hi = (min_pulse_reg < max_pulse_reg) ? max_pulse_reg : min_pulse_reg;
    lo = (lo < 40) ? 0 : lo - 40;
    hi = (hi > 4055) ? 4095 : hi + 40;
    return sfe_pkg::PULSE_W'($urandom_range(hi, lo));
  endfunction

  task automatic send_random_frames(input int frames);
    for (int f = 0; f < frames; f++)
      for (int ch = 0; ch < sfe_pkg::TOTAL_CHANNELS; ch++)
        send_pulse(random_width(ch));
  endtask

  task automatic test_directed_extremes();
    for (int ch = 0; ch < sfe_pkg::TOTAL_CHANNELS; ch++)
      send_pulse(DIRECTED_WIDTHS[ch]);
    drain_and_settle();
  endtask

  // Inverted and zero-width ranges must both give the bottom code on every analog channel.
  task automatic test_empty_range();
    set_pulse_range(12'd4095, 12'd0);
    send_random_frames(1);
    drain_and_settle();
    set_pulse_range(12'd1500, 12'd1500);
    send_random_frames(1);
    drain_and_settle();
  endtask

  // Spans of 128 and 3200 put odd offsets exactly half way between two codes.
  task automatic test_tie_rounding();
    set_pulse_range(12'd1000, 12'd1128);
    send_random_frames(1);
    drain_and_settle();
    set_pulse_range(12'd100, 12'd3300);
    send_random_frames(1);
    drain_and_settle();
  endtask

  task automatic test_random_ranges();
    logic [sfe_pkg::PULSE_W-1:0] lo;
    lo = sfe_pkg::PULSE_W'($urandom_range(3000));
    set_pulse_range(lo, sfe_pkg::PULSE_W'($urandom_range(4095, lo + 1)));
    send_random_frames(1);
    drain_and_settle();
  endtask

  // The receiver holds off past the first frame, so the output stalls, the command
  // queue fills and the input stalls.
  task automatic test_output_backpressure();
    set_pulse_range(sfe_pkg::MIN_PULSE_RESET, sfe_pkg::MAX_PULSE_RESET);
    sink_hold_cycles = HOLD_OFF_CYCLES;
    send_random_frames(2);
    drain_and_settle();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pulse_if.valid = 1'b0;
    pulse_if.pulse_us = '0;
    min_pulse_reg = sfe_pkg::MIN_PULSE_RESET;
    max_pulse_reg = sfe_pkg::MAX_PULSE_RESET;
    next_channel = 0;
    flag_bits = '0;
    for (int k = 0; k < sfe_pkg::ANALOG_CHANNELS; k++) channel_code[k] = '0;
    send_idle_pct = 20;
    sink_idle_pct = 76;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_empty_range();
    send_idle_pct = 76;
    sink_idle_pct = 20;
    test_tie_rounding();
    test_random_ranges();
    send_idle_pct = 0;
    sink_idle_pct = 0;
    test_output_backpressure();

    if (error_count == 0)
      $display("tb_sbus_frame_encoder_core: done, clean");
    else
      $display("tb_sbus_frame_encoder_core: done, errors");
    $finish;
  end

endmodule
